[src/spgc_pkg.sv]
// ----------------------------------------------------------------------------
// spgc_pkg: shared types and constants for the sector pattern generator/checker
// Holds the pattern mode codes, the request/result payload structs and the
// running checker state that passes between the top level and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spgc_pkg;

  // Pattern mode register codes
  typedef enum logic [1:0] {
    MODE_LCG      = 2'd0,
    MODE_BYTE     = 2'd1,
    MODE_HALFWORD = 2'd2,
    MODE_WORD     = 2'd3
  } spgc_mode_e;

  // LCG increment; the multiplier 8197 is built as (n << 13) + (n << 2) + n
  localparam logic [31:0] LCG_ADD = 32'd13849;

  // Saturation limits of the error counters
  localparam logic [6:0]  SECTOR_CNT_MAX = 7'h7f;
  localparam logic [31:0] TOTAL_CNT_MAX  = 32'hffff_ffff;

  // One request
  typedef struct packed {
    logic        action;
    logic        first_word;
    logic [31:0] sector_offset;
    logic [31:0] read_word;
  } spgc_req_t;

  // One result
  typedef struct packed {
    logic [31:0] expected_word;
    logic        mismatch;
    logic [6:0]  sector_errors;
    logic [31:0] total_errors;
    logic        last_word;
  } spgc_rsp_t;

  // Running state carried from word to word (word index kept apart)
  typedef struct packed {
    logic [31:0] lcg_seed;
    logic [31:0] sector_base;
    logic [6:0]  sector_cnt;
    logic [31:0] total_cnt;
  } spgc_state_t;

endpackage

`default_nettype wire

[src/spgc_if.sv]
// ----------------------------------------------------------------------------
// spgc_if: valid/ready channels for requests and results
// Each channel carries valid, ready and the payload fields; the source drives
// valid and payload, the sink drives ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spgc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        first_word;
  logic [31:0] sector_offset;
  logic [31:0] read_word;

  modport source (output valid, action, first_word, sector_offset, read_word,
                  input ready);
  modport sink   (input valid, action, first_word, sector_offset, read_word,
                  output ready);
endinterface

interface spgc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] expected_word;
  logic        mismatch;
  logic [6:0]  sector_errors;
  logic [31:0] total_errors;
  logic        last_word;

  modport source (output valid, expected_word, mismatch, sector_errors,
                  total_errors, last_word, input ready);
  modport sink   (input valid, expected_word, mismatch, sector_errors,
                  total_errors, last_word, output ready);
endinterface

`default_nettype wire

[src/sector_pattern_gen_check.sv]
// ----------------------------------------------------------------------------
// sector_pattern_gen_check: storage test pattern generator and checker
// Produces the expected pattern word for each word of a sector and, in check
// mode, compares it with the word read back and counts mismatches.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one request per 32-bit word: action (0 generate, 1 check),
//   first_word (restart the sector from sector_offset), sector_offset and
//   read_word. out_chan returns one result per request, in order: the
//   expected word, the mismatch flag, the per-sector and saturating total
//   error counts, and a flag on the last word of the sector.
//   cfg_we_i/cfg_wdata_i write pattern_mode (LCG, byte, halfword or word
//   counting); write it only while no request is in flight.
//   A request passes through one input register, then the pattern/compare
//   logic feeding the result register. Throughput is one word per cycle while
//   the receiver takes results; the LCG step is a shift-and-add constant
//   multiply that fits between those two registers.
//   Reset clears the mode to LCG, the seed, base, word index and both error
//   counters. When the receiver stalls, the result register holds and the
//   input register fills; ready drops only once both are occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sector_pattern_gen_check #(
  parameter int unsigned SECTOR_BYTES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  spgc_in_if.sink          in_chan,
  spgc_out_if.source       out_chan
);

  localparam int unsigned WORDS = SECTOR_BYTES / 4;
  localparam int unsigned IDX_W = $clog2(WORDS);

  spgc_pkg::spgc_mode_e  mode_q;
  spgc_pkg::spgc_req_t   req_q;
  logic                  req_vld_q;
  spgc_pkg::spgc_rsp_t   rsp_q;
  spgc_pkg::spgc_rsp_t   rsp_d;
  logic                  rsp_vld_q;
  spgc_pkg::spgc_state_t state_q;
  spgc_pkg::spgc_state_t state_d;
  logic [IDX_W-1:0]      idx_q;
  logic [IDX_W-1:0]      idx_d;
  logic                  rsp_free;
  logic                  advance;
  logic                  req_take;

  // Handshake control
  assign rsp_free       = !rsp_vld_q || out_chan.ready;
  assign advance        = req_vld_q && rsp_free;
  assign in_chan.ready  = !req_vld_q || rsp_free;
  assign req_take       = in_chan.valid && in_chan.ready;

  // Hold the pattern mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= spgc_pkg::MODE_LCG;
    end else if (cfg_we_i) begin
      mode_q <= spgc_pkg::spgc_mode_e'(cfg_wdata_i);
    end
  end

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (in_chan.ready) begin
      req_vld_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      req_q.action        <= in_chan.action;
      req_q.first_word    <= in_chan.first_word;
      req_q.sector_offset <= in_chan.sector_offset;
      req_q.read_word     <= in_chan.read_word;
    end
  end

  spgc_datapath #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_datapath (
    .mode_i  (mode_q),
    .req_i   (req_q),
    .state_i (state_q),
    .idx_i   (idx_q),
    .state_o (state_d),
    .idx_o   (idx_d),
    .rsp_o   (rsp_d)
  );

  // Advance the running state as each word moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      idx_q   <= '0;
    end else if (advance) begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (rsp_free) begin
      rsp_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_chan.valid         = rsp_vld_q;
  assign out_chan.expected_word = rsp_q.expected_word;
  assign out_chan.mismatch      = rsp_q.mismatch;
  assign out_chan.sector_errors = rsp_q.sector_errors;
  assign out_chan.total_errors  = rsp_q.total_errors;
  assign out_chan.last_word     = rsp_q.last_word;

  // Word index stays inside the sector
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(WORDS - 1))
    else $error("word index beyond sector");

  // A mismatch is always reflected in the sector count
  a_mis_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && rsp_q.mismatch) |-> (rsp_q.sector_errors != 7'd0))
    else $error("mismatch without sector count");

  // Total error count never goes down
  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (state_q.total_cnt >= $past(state_q.total_cnt)))
    else $error("total error count decreased");

  // A word leaving the input register lands in the result register
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> rsp_vld_q)
    else $error("advanced word lost");

endmodule

`default_nettype wire

[src/spgc_datapath.sv]
// ----------------------------------------------------------------------------
// spgc_datapath: per-word pattern generation and compare
// From the current state and one request, forms the expected word, the
// mismatch flag, the updated counters and the next state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spgc_datapath #(
  parameter int unsigned SECTOR_BYTES = 256
) (
  input  spgc_pkg::spgc_mode_e                       mode_i,
  input  spgc_pkg::spgc_req_t                        req_i,
  input  spgc_pkg::spgc_state_t                      state_i,
  input  logic [$clog2(SECTOR_BYTES / 4)-1:0]        idx_i,
  output spgc_pkg::spgc_state_t                      state_o,
  output logic [$clog2(SECTOR_BYTES / 4)-1:0]        idx_o,
  output spgc_pkg::spgc_rsp_t                        rsp_o
);

  localparam int unsigned WORDS = SECTOR_BYTES / 4;
  localparam int unsigned IDX_W = $clog2(WORDS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WORDS - 1);

  logic [31:0]      seed;
  logic [31:0]      base;
  logic [IDX_W-1:0] idx;
  logic [6:0]       cnt_start;
  logic [31:0]      lcg;
  logic [31:0]      addr;
  logic [7:0]       byte0;
  logic [15:0]      half0;
  logic [31:0]      expected;
  logic             mis;
  logic             last;

  // Restart the sector on a first word
  assign seed      = req_i.first_word ? req_i.sector_offset : state_i.lcg_seed;
  assign base      = req_i.first_word ? req_i.sector_offset : state_i.sector_base;
  assign idx       = req_i.first_word ? '0 : idx_i;
  assign cnt_start = (idx == '0) ? 7'd0 : state_i.sector_cnt;

  // LCG step: n * 8197 + 13849
  assign lcg = (seed << 13) + (seed << 2) + seed + spgc_pkg::LCG_ADD;

  // Byte position of this word
  assign addr  = base + {{(32 - IDX_W - 2){1'b0}}, idx, 2'b00};
  assign byte0 = addr[7:0];
  assign half0 = addr[15:0];

  // Select the pattern word
  always_comb begin
    case (mode_i)
      spgc_pkg::MODE_LCG:      expected = lcg;
      spgc_pkg::MODE_BYTE:     expected = {byte0, byte0 + 8'd1, byte0 + 8'd2,
                                           byte0 + 8'd3};
      spgc_pkg::MODE_HALFWORD: expected = {half0, half0 + 16'd2};
      spgc_pkg::MODE_WORD:     expected = addr;
      default:                 expected = addr;
    endcase
  end

  assign mis  = req_i.action && (req_i.read_word != expected);
  assign last = (idx == IDX_LAST);

  // Advance state and saturate the counters
  always_comb begin
    state_o.lcg_seed    = (mode_i == spgc_pkg::MODE_LCG) ? lcg : seed;
    state_o.sector_base = base;
    state_o.sector_cnt  = cnt_start;
    state_o.total_cnt   = state_i.total_cnt;
    if (mis) begin
      if (cnt_start != spgc_pkg::SECTOR_CNT_MAX) begin
        state_o.sector_cnt = cnt_start + 7'd1;
      end
      if (state_i.total_cnt != spgc_pkg::TOTAL_CNT_MAX) begin
        state_o.total_cnt = state_i.total_cnt + 32'd1;
      end
    end
  end

  assign idx_o = last ? '0 : idx + IDX_W'(1);

  assign rsp_o.expected_word = expected;
  assign rsp_o.mismatch      = mis;
  assign rsp_o.sector_errors = state_o.sector_cnt;
  assign rsp_o.total_errors  = state_o.total_cnt;
  assign rsp_o.last_word     = last;

endmodule

`default_nettype wire
